// File: design/blar_pkg.sv
// Shared types and constants for the bounded list append/remove block.
package blar_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W = 2;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int ST_W = 2;

    localparam int CAPACITY_DEF = 64;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    localparam logic [ST_W-1:0] ST_OK = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    // Request token; one cell down the chain per cycle unless frozen.
    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  index;
        logic              found;
        logic [DATA_W-1:0] rdata;
    } t_tok;

endpackage

// File: design/blar_cell.sv
// One list cell: holds a single entry and forwards the request token to its neighbor.
module blar_cell #(
    parameter int POS = 0,
    parameter int CW = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [CW-1:0]               i_count,
    input  blar_pkg::t_tok              i_tok,
    input  logic [blar_pkg::DATA_W-1:0] i_next_data,
    output logic [blar_pkg::DATA_W-1:0] o_data,
    output blar_pkg::t_tok              o_tok
);

    // Positions above the index field's reach can never be read.
    localparam bit REACH = (POS < (2 ** blar_pkg::IDX_W));

    logic [blar_pkg::DATA_W-1:0] r_data;
    blar_pkg::t_tok              r_tok;
    blar_pkg::t_tok              n_tok;
    logic                        w_occupied;
    logic                        w_hit;
    logic                        w_at_index;

    assign w_occupied = (CW'(POS) < i_count);
    assign w_hit = (i_tok.op == blar_pkg::OP_REMOVE) && !i_tok.found && w_occupied &&
                   (r_data == i_tok.value);
    assign w_at_index = REACH && (i_tok.index == blar_pkg::IDX_W'(POS));

    always_comb begin
        n_tok = i_tok;
        n_tok.found = i_tok.found || w_hit;
        if ((i_tok.op == blar_pkg::OP_READ) && w_occupied && w_at_index) begin
            n_tok.rdata = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_tok <= n_tok;
        end
    end

    // Entry update: append writes at the tail, remove pulls the right neighbor's entry in
    // from the first match onward.
    always_ff @(posedge i_clk) begin
        if (i_en && i_tok.valid) begin
            if ((i_tok.op == blar_pkg::OP_APPEND) && (i_count == CW'(POS))) begin
                r_data <= i_tok.value;
            end else if ((i_tok.op == blar_pkg::OP_REMOVE) && (i_tok.found || w_hit)) begin
                r_data <= i_next_data;
            end
        end
    end

    assign o_data = r_data;
    assign o_tok = r_tok;

endmodule

// File: design/bounded_list_append_remove_core.sv
// Top level of the bounded ordered list with append, remove-by-value and indexed read.
//
// Usage: a request (opcode, value, index) is transferred on the input channel when
// i_in_valid is high and o_in_stall is low. Each request yields exactly one result
// (read_data, count, status) on the output channel, transferred when o_out_valid is
// high and i_out_stall is low. Opcode three is a no-operation that reports status ok.
// The list lives in a row of CAPACITY cells. A request enters cell 0 as a token and
// moves one cell per clock unless the chain is frozen; every cell compares, shifts or
// captures its own entry as the token passes, so a remove closes its gap in the same
// single sweep. o_out_valid rises once the token has left the last cell and the result
// is registered. A new request is taken only once the previous token has left the
// chain; o_in_stall stays high while a token is in the chain.
// A finished result sits in an output register, so a new request can be taken while
// the previous result still waits. If a token reaches the end of the chain while the
// output register is full and stalled, the chain freezes until the result is taken.
// Reset (synchronous, active low) empties the list and drops any request in flight.
// Entry contents are not cleared; only positions below the count are ever read.
module bounded_list_append_remove_core #(
    parameter int CAPACITY = blar_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [blar_pkg::OP_W-1:0]          i_opcode,
    input  logic signed [blar_pkg::DATA_W-1:0] i_value,
    input  logic [blar_pkg::IDX_W-1:0]         i_index,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [blar_pkg::DATA_W-1:0] o_read_data,
    output logic [blar_pkg::CNT_W-1:0]         o_count,
    output logic [blar_pkg::ST_W-1:0]          o_status
);

    // Count width holds 0..CAPACITY; the compare width covers both count and index.
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > blar_pkg::IDX_W) ? CW : blar_pkg::IDX_W;

    logic                        r_busy;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic                        r_out_valid;
    logic [blar_pkg::DATA_W-1:0] r_read_data;
    logic [blar_pkg::CNT_W-1:0]  r_out_count;
    logic [blar_pkg::ST_W-1:0]   r_status;
    logic [blar_pkg::ST_W-1:0]   n_status;
    logic [blar_pkg::DATA_W-1:0] n_read_data;

    blar_pkg::t_tok              w_tok [CAPACITY+1];
    logic [blar_pkg::DATA_W-1:0] w_data [CAPACITY+1];
    logic [CAPACITY-1:0]         w_tok_valid;
    blar_pkg::t_tok              w_last;
    logic                        w_in_xfer;
    logic                        w_adv;
    logic                        w_done;
    logic                        w_idx_ok;
    logic [CW+blar_pkg::CNT_W-1:0] w_cnt_ext;

    assign o_in_stall = r_busy;
    assign w_in_xfer = i_in_valid && !r_busy;

    // The token that enters the head of the chain.
    always_comb begin
        w_tok[0].valid = w_in_xfer;
        w_tok[0].op = i_opcode;
        w_tok[0].value = i_value;
        w_tok[0].index = i_index;
        w_tok[0].found = 1'b0;
        w_tok[0].rdata = '0;
    end

    // Beyond the last cell there is no entry to pull in.
    assign w_data[CAPACITY] = '0;

    assign w_last = w_tok[CAPACITY];
    // Freeze the chain only when a finished token has nowhere to go.
    assign w_adv = !(w_last.valid && r_out_valid && i_out_stall);
    assign w_done = w_last.valid && w_adv;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        blar_cell #(
            .POS (k),
            .CW  (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (w_adv),
            .i_count     (r_count),
            .i_tok       (w_tok[k]),
            .i_next_data (w_data[k+1]),
            .o_data      (w_data[k]),
            .o_tok       (w_tok[k+1])
        );
        assign w_tok_valid[k] = w_tok[k+1].valid;
    end

    assign w_idx_ok = (MW'(w_last.index) < MW'(r_count));

    // Final status and count once the token has visited every cell.
    always_comb begin
        n_count = r_count;
        n_status = blar_pkg::ST_OK;
        n_read_data = '0;
        case (w_last.op)
            blar_pkg::OP_APPEND: begin
                if (r_count >= CW'(CAPACITY)) begin
                    n_status = blar_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            blar_pkg::OP_REMOVE: begin
                if (w_last.found) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_status = blar_pkg::ST_NOT_FOUND;
                end
            end
            blar_pkg::OP_READ: begin
                if (w_idx_ok) begin
                    n_read_data = w_last.rdata;
                end else begin
                    n_status = blar_pkg::ST_RANGE;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // The count field reports the count modulo 128 for very wide lists.
    assign w_cnt_ext = {{blar_pkg::CNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_done) begin
                r_count <= n_count;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_read_data <= n_read_data;
            r_out_count <= w_cnt_ext[blar_pkg::CNT_W-1:0];
            r_status <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_count = r_out_count;
    assign o_status = r_status;

    // At most one request is ever travelling through the chain.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_valid))
        else $error("more than one token in the cell chain");

    // No token may be in the chain while the input side is open.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (w_tok_valid == '0))
        else $error("token in chain while not busy");

    // The count never exceeds the capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // The count only moves when a request completes.
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_done |=> $stable(r_count))
        else $error("entry count changed without a completed request");

endmodule

// File: sim/tb_bounded_list_append_remove_core.sv
// Self-checking testbench for the bounded list core: directed and random requests with checks.
`timescale 1ns / 1ps

module tb_bounded_list_append_remove_core;

    import blar_pkg::*;

    // The chain length sets both latency and throughput, so the run keeps the
    // default capacity and sizes its waits from it.
    localparam int CAP = CAPACITY_DEF;
    localparam int N_ITEMS = 450;
    localparam int DRAIN_AT = 300;        // request that waits for an empty pipe
    localparam int QUIET_TAIL = 40;       // last requests run without idling
    localparam int LONG_HOLD = 400;       // receiver hold-off, in cycles
    localparam int LONG_HOLD_AT = 120;    // results seen before the hold-off starts
    localparam int CYCLE_LIMIT = 500000;

    // The package has no name for opcode three, which is a no-operation.
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         index;
        logic                     drain;   // hold this request until all results are in
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]         count;
        logic [ST_W-1:0]          status;
    } t_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [OP_W-1:0]          i_opcode = OP_NOP;
    logic signed [DATA_W-1:0] i_value = '0;
    logic [IDX_W-1:0]         i_index = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_read_data;
    logic [CNT_W-1:0]         o_count;
    logic [ST_W-1:0]          o_status;

    bounded_list_append_remove_core #(
        .CAPACITY(CAP)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_opcode   (i_opcode),
        .i_value    (i_value),
        .i_index    (i_index),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_read_data(o_read_data),
        .o_count    (o_count),
        .o_status   (o_status)
    );

    // Requests waiting to be offered, and the results that accepted requests must produce.
    t_req    req_backlog[$];
    t_result want_results[$];

    // Predicted contents of the list, oldest entry first.
    logic signed [DATA_W-1:0] held[$];

    // Counters shared between processes, except mismatch_count and cycle_cnt, use nonblocking
    // assignments so that every reader sees the value from before the edge.
    int n_total = 0;
    int n_sent = 0;
    int n_seen = 0;
    int mismatch_count = 0;
    int op_seen[4] = '{0, 0, 0, 0};
    int status_seen[4] = '{0, 0, 0, 0};
    int peak_count = 0;
    int unsigned cycle_cnt = 0;

    // Applies one request to the predicted list and returns the result it must produce.
    // Entries past the count are never read, since a read there reports out of range.
    function automatic t_result list_step(input t_req req);
        t_result res;
        int hit;
        res.read_data = '0;
        res.status = ST_OK;
        hit = -1;
        case (req.op)
            OP_APPEND: begin
                if (held.size() >= CAP) begin
                    res.status = ST_FULL;
                end else begin
                    held.push_back(req.value);
                end
            end
            OP_REMOVE: begin
                // Only the first equal entry goes; later ones close up behind it.
                for (int i = 0; i < held.size(); i++) begin
                    if (held[i] == req.value) begin
                        hit = i;
                        break;
                    end
                end
                if (hit < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    held.delete(hit);
                end
            end
            OP_READ: begin
                if (int'(req.index) < held.size()) begin
                    res.read_data = held[req.index];
                end else begin
                    res.status = ST_RANGE;
                end
            end
            default: begin
            end
        endcase
        res.count = CNT_W'(held.size());
        return res;
    endfunction

    // Stimulus generation runs the predictor too, so that removes can aim at
    // values that are present and reads at live positions. The predicted list
    // is cleared again before the run starts.
    task automatic queue_request(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value,
                                 input logic [IDX_W-1:0] index);
        t_req req;
        t_result unused;
        req.op = op;
        req.value = value;
        req.index = index;
        req.drain = (req_backlog.size() == DRAIN_AT);
        req_backlog.push_back(req);
        unused = list_step(req);
    endtask

    // Values come often from a small pool, so duplicates and the signed extremes
    // recur, and otherwise from the full 32-bit range.
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'sh8000_0000;
            1: v = 32'sh7FFF_FFFF;
            2: v = -32'sd1;
            3: v = 32'sd0;
            4: v = 32'sd7;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_present();
        if (held.size() > 0 && $urandom_range(0, 4) != 0) begin
            return held[$urandom_range(0, held.size() - 1)];
        end
        return pick_value();
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        if (held.size() > 0 && $urandom_range(0, 4) != 0) begin
            return IDX_W'($urandom_range(0, held.size() - 1));
        end
        return IDX_W'($urandom_range(0, 63));
    endfunction

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Driver. The payload is loaded once per request and held until the
    // transfer, so a stalled payload never changes. After a transfer the
    // sender may sit idle for a chain of short bursts, which moves its next
    // offer across the whole busy window of the chain.
    t_req cur_req;
    logic presenting = 1'b0;
    logic fire;
    int idle_left = 0;
    int outstanding;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            fire = i_in_valid && !o_in_stall;
            if (fire) begin
                want_results.push_back(list_step(cur_req));
                op_seen[cur_req.op] <= op_seen[cur_req.op] + 1;
                n_sent <= n_sent + 1;
                presenting = 1'b0;
                if (n_sent + QUIET_TAIL < n_total && $urandom_range(0, 2) == 0) begin
                    repeat ($urandom_range(1, 16)) idle_left += $urandom_range(1, 5);
                end
            end
            outstanding = n_sent + int'(fire) - n_seen;
            if (!presenting) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (req_backlog.size() > 0
                             && !(req_backlog[0].drain && outstanding != 0)) begin
                    cur_req = req_backlog.pop_front();
                    presenting = 1'b1;
                    i_opcode <= cur_req.op;
                    i_value <= cur_req.value;
                    i_index <= cur_req.index;
                end
            end
            i_in_valid <= presenting;
        end
    end

    // Receiver. Short stall bursts at random, one long hold-off once enough
    // results have come so that the chain and the output register both fill
    // and the input side stalls, and no stalls at all near the end.
    int stall_left = 0;
    logic long_hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_left == 0 && !long_hold_done && n_seen >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && n_sent + QUIET_TAIL < n_total
                         && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 5);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Monitor. Every result transfer is matched against the oldest prediction.
    t_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_seen <= n_seen + 1;
            status_seen[o_status] <= status_seen[o_status] + 1;
            if (int'(o_count) > peak_count) begin
                peak_count <= int'(o_count);
            end
            if (want_results.size() == 0) begin
                $error("result with nothing expected: read_data %0d count %0d status %0d",
                       o_read_data, o_count, o_status);
                mismatch_count++;
            end else begin
                want = want_results.pop_front();
                if (o_read_data !== want.read_data) begin
                    $error("read_data: expected %0d, got %0d", want.read_data, o_read_data);
                    mismatch_count++;
                end
                if (o_count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, o_count);
                    mismatch_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on the cycle count.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles", cycle_cnt);
        $display("tb: failure");
        $finish;
    end

    // Builds the request list, releases reset, and waits for the run to drain.
    initial begin
        int roll;

        // Directed part: empty-list reads and remove, no-op, signed extremes,
        // a duplicate so that remove must take the first match, removal from
        // the middle, head and tail, and a read past the count.
        queue_request(OP_READ, 32'sd0, 6'd0);
        queue_request(OP_READ, -32'sd1, 6'd63);
        queue_request(OP_REMOVE, 32'sd0, 6'd0);
        queue_request(OP_NOP, -32'sd1, 6'd63);
        queue_request(OP_APPEND, 32'sh8000_0000, 6'd63);
        queue_request(OP_APPEND, 32'sh7FFF_FFFF, 6'd0);
        queue_request(OP_APPEND, 32'sd0, 6'd0);
        queue_request(OP_APPEND, -32'sd1, 6'd0);
        queue_request(OP_APPEND, 32'sh7FFF_FFFF, 6'd0);
        for (int i = 0; i < 5; i++) begin
            queue_request(OP_READ, 32'sd0, IDX_W'(i));
        end
        queue_request(OP_REMOVE, 32'sh7FFF_FFFF, 6'd0);
        queue_request(OP_READ, 32'sd0, 6'd1);
        queue_request(OP_READ, 32'sd0, 6'd3);
        queue_request(OP_READ, 32'sd0, 6'd4);
        queue_request(OP_REMOVE, 32'sd12345, 6'd0);
        queue_request(OP_REMOVE, 32'sh8000_0000, 6'd0);
        queue_request(OP_REMOVE, -32'sd1, 6'd0);
        queue_request(OP_REMOVE, 32'sh7FFF_FFFF, 6'd0);
        queue_request(OP_READ, 32'sd0, 6'd0);
        queue_request(OP_NOP, 32'sd0, 6'd0);

        // Random part in phases: grow the list until it is full, poke at the
        // full list, then shrink it mostly by removing values that are present.
        // Every phase stops once the request list has reached its length.
        while (req_backlog.size() < N_ITEMS) begin
            while (held.size() < CAP && req_backlog.size() < N_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    queue_request(OP_APPEND, pick_value(), IDX_W'($urandom));
                end else if (roll < 80) begin
                    queue_request(OP_REMOVE, pick_present(), IDX_W'($urandom));
                end else if (roll < 95) begin
                    queue_request(OP_READ, pick_value(), pick_index());
                end else begin
                    queue_request(OP_NOP, $urandom, IDX_W'($urandom));
                end
            end
            repeat (6) begin
                if (req_backlog.size() >= N_ITEMS) break;
                if ($urandom_range(0, 9) < 6) begin
                    queue_request(OP_APPEND, pick_value(), IDX_W'($urandom));
                end else begin
                    queue_request(OP_READ, pick_value(), pick_index());
                end
            end
            repeat ($urandom_range(40, 100)) begin
                if (req_backlog.size() >= N_ITEMS) break;
                roll = $urandom_range(0, 99);
                if (roll < 15) begin
                    queue_request(OP_APPEND, pick_value(), IDX_W'($urandom));
                end else if (roll < 65) begin
                    queue_request(OP_REMOVE, pick_present(), IDX_W'($urandom));
                end else if (roll < 90) begin
                    queue_request(OP_READ, pick_value(), pick_index());
                end else begin
                    queue_request(OP_NOP, $urandom, IDX_W'($urandom));
                end
            end
        end
        n_total = req_backlog.size();
        held.delete();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent < n_total || n_seen < n_total) @(posedge i_clk);
        // Let any stray result surface before the verdict.
        repeat (CAP + 8) @(posedge i_clk);
        if (want_results.size() != 0) begin
            $error("%0d expected results never arrived", want_results.size());
            mismatch_count++;
        end

        $display("summary: %0d requests (%0d append, %0d remove, %0d read, %0d no-op) in %0d cycles",
                 n_sent, op_seen[OP_APPEND], op_seen[OP_REMOVE], op_seen[OP_READ],
                 op_seen[OP_NOP], cycle_cnt);
        $display("summary: status ok %0d, full %0d, not found %0d, out of range %0d, peak count %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NOT_FOUND],
                 status_seen[ST_RANGE], peak_count);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: bounded_list_append_remove_core.f
design/blar_pkg.sv
design/blar_cell.sv
design/bounded_list_append_remove_core.sv
sim/tb_bounded_list_append_remove_core.sv
